FILE: sv/bas_pkg.sv
// Shared types, constants and helpers for the battery alert supervisor.
package bas_pkg;

    localparam int unsigned TIMER_W = 32;
    localparam int unsigned DT_W    = 20;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned SEL_W   = 3;

    localparam logic [TIMER_W-1:0] CHECK_PERIOD_US = 32'd20000000;
    localparam logic [TIMER_W-1:0] FAST_BLINK_US   = 32'd1000000;
    localparam logic [TIMER_W-1:0] SLOW_BLINK_US   = 32'd5000000;
    localparam logic [TIMER_W-1:0] BLINK_ON_US     = 32'd100000;
    localparam logic [TIMER_W-1:0] MINUTE_US       = 32'd60000000;

    // Item kinds carried in the input tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    // Auto-off selector codes
    localparam logic [SEL_W-1:0] SEL_OFF    = 3'd0;
    localparam logic [SEL_W-1:0] SEL_1_MIN  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_5_MIN  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_15_MIN = 3'd3;
    localparam logic [SEL_W-1:0] SEL_30_MIN = 3'd4;

    // Register indexes on the APB port (word address)
    localparam logic [1:0] REG_AUTO_OFF = 2'd0;
    localparam logic [1:0] REG_WARN     = 2'd1;
    localparam logic [1:0] REG_CRITICAL = 2'd2;
    localparam logic [1:0] REG_EMPTY    = 2'd3;

    typedef struct packed {
        logic [SEL_W-1:0] auto_off_select;
        logic [PCT_W-1:0] warn_percent;
        logic [PCT_W-1:0] critical_percent;
        logic [PCT_W-1:0] empty_percent;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_W-1:0] check_timer;
        logic [TIMER_W-1:0] blink_timer;
        logic [TIMER_W-1:0] idle_timer;
        logic               blink_active;
        logic               warning_given;
        logic               halted;
    } state_t;

    typedef struct packed {
        logic             operation;
        logic [DT_W-1:0]  elapsed_us;
        logic [PCT_W-1:0] battery_percent;
        logic             voltage_valid;
        logic             ui_transition_busy;
        logic             shutdown_popup_open;
        logic             warning_popup_open;
    } item_t;

    typedef struct packed {
        logic led_on;
        logic power_off;
        logic raise_shutdown;
        logic raise_warning;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [DT_W-1:0] b);
        logic [TIMER_W:0] sum;
        begin
            sum = {1'b0, a} + {{(TIMER_W+1-DT_W){1'b0}}, b};
            sat_add = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
        end
    endfunction

    function automatic logic sel_enabled(input logic [SEL_W-1:0] sel);
        begin
            sel_enabled = (sel == SEL_1_MIN) || (sel == SEL_5_MIN) ||
                          (sel == SEL_15_MIN) || (sel == SEL_30_MIN);
        end
    endfunction

    // Inactivity limit in microseconds for each selector code
    function automatic logic [TIMER_W-1:0] off_limit(input logic [SEL_W-1:0] sel);
        begin
            case (sel)
                SEL_1_MIN:  off_limit = MINUTE_US;
                SEL_5_MIN:  off_limit = 32'(MINUTE_US * 32'd5);
                SEL_15_MIN: off_limit = 32'(MINUTE_US * 32'd15);
                SEL_30_MIN: off_limit = 32'(MINUTE_US * 32'd30);
                default:    off_limit = '0;
            endcase
        end
    endfunction

endpackage

FILE: sv/battery_alert_supervisor.sv
// Top level of the battery alert supervisor: stream ports, APB registers, state.
//
// Usage:
//   Items enter on the s_axis channel. tuser[0] says what the beat is: a time
//   tick or a key press. tdata carries elapsed time, battery percent and the
//   UI status flags. Each accepted beat yields exactly one result beat on the
//   m_axis channel (LED level, power-off request, shutdown and warning alerts).
//   The beat is captured in an input register, then evaluated against the timer
//   state, and the result is loaded into the result register.
//   Throughput is one beat per cycle unless m_axis stalls; the single
//   evaluation stage updates the check, blink and inactivity timers in one
//   pass of saturating adds and compares, so a new beat may follow every cycle.
//   When the receiver stalls (m_axis_tready low) the result register holds its
//   beat, the input register holds one more, and s_axis_tready then drops.
//   Registers are written over APB at word addresses 0..3; any write also
//   clears the inactivity timer. Write them only while no beat is in flight.
//   Reset (rst_n low) clears all timers, flags and the halted latch, and loads
//   the register defaults (auto-off off, warn 15, critical 5, empty 1).
//   Once power-off has been requested, every later beat answers power-off.
module battery_alert_supervisor (
    input  logic        clk,
    input  logic        rst_n,
    // Item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [19:0] elapsed_us, [26:20] battery_percent, [27] voltage_valid,
    // [28] ui_transition_busy, [29] shutdown_popup_open,
    // [30] warning_popup_open, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [0] operation
    input  logic [0:0]  s_axis_tuser,
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] led_on, [1] power_off, [2] raise_shutdown, [3] raise_warning,
    // [7:4] zero
    output logic [7:0]  m_axis_tdata,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bas_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  st_reg;
    state_t  st_next;
    state_t  st_step;
    item_t   item_reg;
    item_t   item_in;
    result_t res_reg;
    result_t res_step;
    logic    in_vld_reg;
    logic    out_vld_reg;
    logic    out_free;
    logic    advance;
    logic    in_take;
    logic    cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Unpack the input beat
    assign item_in.operation           = s_axis_tuser[0];
    assign item_in.elapsed_us          = s_axis_tdata[19:0];
    assign item_in.battery_percent     = s_axis_tdata[26:20];
    assign item_in.voltage_valid       = s_axis_tdata[27];
    assign item_in.ui_transition_busy  = s_axis_tdata[28];
    assign item_in.shutdown_popup_open = s_axis_tdata[29];
    assign item_in.warning_popup_open  = s_axis_tdata[30];

    // Handshake: the result register frees when empty or taken this cycle
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, res_reg.raise_warning, res_reg.raise_shutdown,
                            res_reg.power_off, res_reg.led_on};

    bas_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_step),
        .res     (res_step)
    );

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_idx)
            REG_AUTO_OFF:
            begin
                prdata[SEL_W-1:0] = cfg_reg.auto_off_select;
                if (cfg_wr)
                begin
                    cfg_next.auto_off_select = pwdata[SEL_W-1:0];
                end
            end
            REG_WARN:
            begin
                prdata[PCT_W-1:0] = cfg_reg.warn_percent;
                if (cfg_wr)
                begin
                    cfg_next.warn_percent = pwdata[PCT_W-1:0];
                end
            end
            REG_CRITICAL:
            begin
                prdata[PCT_W-1:0] = cfg_reg.critical_percent;
                if (cfg_wr)
                begin
                    cfg_next.critical_percent = pwdata[PCT_W-1:0];
                end
            end
            REG_EMPTY:
            begin
                prdata[PCT_W-1:0] = cfg_reg.empty_percent;
                if (cfg_wr)
                begin
                    cfg_next.empty_percent = pwdata[PCT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // State update: a register write clears the inactivity timer
    always_comb
    begin
        st_next = st_reg;
        if (advance)
        begin
            st_next = st_step;
        end
        if (cfg_wr)
        begin
            st_next.idle_timer = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_off_select  <= SEL_OFF;
            cfg_reg.warn_percent     <= 7'd15;
            cfg_reg.critical_percent <= 7'd5;
            cfg_reg.empty_percent    <= 7'd1;
            st_reg                   <= '0;
            in_vld_reg               <= 1'b0;
            out_vld_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on capture and on evaluation
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            res_reg <= res_step;
        end
    end

endmodule

FILE: sv/bas_step.sv
// Next-state and result logic for one supervisor item.
module bas_step (
    input  bas_pkg::cfg_t    cfg,
    input  bas_pkg::state_t  st,
    input  bas_pkg::item_t   item,
    output bas_pkg::state_t  st_next,
    output bas_pkg::result_t res
);
    import bas_pkg::*;

    logic [TIMER_W-1:0] ck_adv;
    logic [TIMER_W-1:0] bt_adv;
    logic [TIMER_W-1:0] id_adv;
    logic               auto_on;
    logic               at_empty;
    logic               at_warn;
    logic               at_crit;

    assign ck_adv   = sat_add(st.check_timer, item.elapsed_us);
    assign bt_adv   = sat_add(st.blink_timer, item.elapsed_us);
    assign id_adv   = sat_add(st.idle_timer, item.elapsed_us);
    assign auto_on  = sel_enabled(cfg.auto_off_select);
    assign at_empty = item.battery_percent <= cfg.empty_percent;
    assign at_warn  = item.battery_percent <= cfg.warn_percent;
    assign at_crit  = item.battery_percent <= cfg.critical_percent;

    always_comb
    begin
        st_next    = st;
        res        = '0;
        res.led_on = st.blink_active;
        if (st.halted)
        begin
            res.led_on    = 1'b0;
            res.power_off = 1'b1;
        end
        else if (item.operation == OP_KEY)
        begin
            st_next.idle_timer = '0;
        end
        else
        begin
            st_next.check_timer = ck_adv;
            st_next.blink_timer = bt_adv;
            if (auto_on)
            begin
                st_next.idle_timer = id_adv;
            end
            if (auto_on && (id_adv >= off_limit(cfg.auto_off_select)))
            begin
                st_next.halted = 1'b1;
                res.led_on     = 1'b0;
                res.power_off  = 1'b1;
            end
            else if (item.voltage_valid)
            begin
                // Blinker: end the on-phase, or start one when the period is due
                if (st.blink_active)
                begin
                    if (bt_adv >= BLINK_ON_US)
                    begin
                        st_next.blink_active = 1'b0;
                        st_next.blink_timer  = '0;
                    end
                end
                else if (((bt_adv >= FAST_BLINK_US) && at_crit) ||
                         ((bt_adv >= SLOW_BLINK_US) && at_warn))
                begin
                    st_next.blink_active = 1'b1;
                    st_next.blink_timer  = '0;
                end
                res.led_on = st_next.blink_active;

                // Alert check; do not clear the check timer while the UI blocks the alert
                if (ck_adv >= CHECK_PERIOD_US)
                begin
                    if (at_empty)
                    begin
                        if (!(item.ui_transition_busy || item.shutdown_popup_open ||
                              item.warning_popup_open))
                        begin
                            res.raise_shutdown  = 1'b1;
                            st_next.check_timer = '0;
                        end
                    end
                    else if (at_warn && !st.warning_given)
                    begin
                        if (!(item.ui_transition_busy || item.shutdown_popup_open))
                        begin
                            res.raise_warning     = 1'b1;
                            st_next.warning_given = 1'b1;
                            st_next.check_timer   = '0;
                        end
                    end
                    else
                    begin
                        st_next.check_timer = '0;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the battery alert supervisor: stream beats, APB setup, alert checks.
`timescale 1ns / 1ps

module tb_top;
    import bas_pkg::*;

    // Hold-off after the last result beat before touching the registers
    // (two-stage pipeline, plus margin).
    localparam int DRAIN_CYCLES = 4;
    // Cycles with no beat on either channel before the run is declared stuck.
    localparam int STALL_LIMIT  = 1000;
    localparam logic [DT_W-1:0]  DT_MAX  = '1;
    localparam logic [PCT_W-1:0] PCT_MAX = '1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [19:0] elapsed_us, [26:20] battery_percent, [27] voltage_valid,
    // [28] ui_transition_busy, [29] shutdown_popup_open,
    // [30] warning_popup_open, [31] zero
    logic [31:0] s_axis_tdata;
    // [0] operation
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] led_on, [1] power_off, [2] raise_shutdown, [3] raise_warning, [7:4] zero
    logic [7:0]  m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    battery_alert_supervisor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the supervisor: registers and timer state.
    // ------------------------------------------------------------------
    logic [SEL_W-1:0]   cfg_sel   = SEL_OFF;
    logic [PCT_W-1:0]   cfg_warn  = 7'd15;
    logic [PCT_W-1:0]   cfg_crit  = 7'd5;
    logic [PCT_W-1:0]   cfg_empty = 7'd1;
    logic [TIMER_W-1:0] st_check_us = '0;
    logic [TIMER_W-1:0] st_blink_us = '0;
    logic [TIMER_W-1:0] st_idle_us  = '0;
    logic               st_led      = 1'b0;
    logic               st_warned   = 1'b0;
    logic               st_halted   = 1'b0;

    item_t   pending_items[$];    // beats queued for the sender
    result_t expected_alerts[$];  // predicted result beats, oldest first
    item_t   beat_item;           // beat currently offered on s_axis
    logic    beat_held = 1'b0;
    int      tx_gap    = 0;
    int      rx_stall  = 0;
    int      stuck_cycles = 0;
    int      errors    = 0;
    bit      no_idling = 1'b0;

    function automatic logic [TIMER_W-1:0] add_sat(input logic [TIMER_W-1:0] acc,
                                                   input logic [DT_W-1:0] step_us);
        logic [TIMER_W:0] sum;
        sum = {1'b0, acc} + {{(TIMER_W+1-DT_W){1'b0}}, step_us};
        return sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
    endfunction

    // Advance the shadow state by one accepted beat and return the alert beat it gives.
    function automatic result_t supervise(input item_t it);
        result_t            r;
        logic [TIMER_W-1:0] off_us;
        r = '0;
        // Once halted, every beat answers power-off and nothing moves.
        if (st_halted) begin
            r.power_off = 1'b1;
            return r;
        end
        // A key press only restarts the inactivity count.
        if (it.operation == OP_KEY) begin
            st_idle_us = '0;
            r.led_on   = st_led;
            return r;
        end
        st_check_us = add_sat(st_check_us, it.elapsed_us);
        st_blink_us = add_sat(st_blink_us, it.elapsed_us);
        if (cfg_sel >= SEL_1_MIN && cfg_sel <= SEL_30_MIN) begin
            case (cfg_sel)
                SEL_1_MIN:  off_us = MINUTE_US;
                SEL_5_MIN:  off_us = MINUTE_US * 32'd5;
                SEL_15_MIN: off_us = MINUTE_US * 32'd15;
                default:    off_us = MINUTE_US * 32'd30;
            endcase
            st_idle_us = add_sat(st_idle_us, it.elapsed_us);
            if (st_idle_us >= off_us) begin
                st_halted   = 1'b1;
                r.power_off = 1'b1;
                return r;
            end
        end
        // Without a voltage reading the blinker and the checks do not act; their timers still advance.
        if (!it.voltage_valid) begin
            r.led_on = st_led;
            return r;
        end
        if (st_led) begin
            if (st_blink_us >= BLINK_ON_US) begin
                st_led      = 1'b0;
                st_blink_us = '0;
            end
        end else if ((st_blink_us >= FAST_BLINK_US && it.battery_percent <= cfg_crit) ||
                     (st_blink_us >= SLOW_BLINK_US && it.battery_percent <= cfg_warn)) begin
            st_led      = 1'b1;
            st_blink_us = '0;
        end
        r.led_on = st_led;
        if (st_check_us >= CHECK_PERIOD_US) begin
            if (it.battery_percent <= cfg_empty) begin
                // Keep the check timer so the next tick retries.
                if (it.ui_transition_busy || it.shutdown_popup_open || it.warning_popup_open)
                    return r;
                r.raise_shutdown = 1'b1;
            end else if (it.battery_percent <= cfg_warn && !st_warned) begin
                if (it.ui_transition_busy || it.shutdown_popup_open)
                    return r;
                st_warned       = 1'b1;
                r.raise_warning = 1'b1;
            end
            st_check_us = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer queued beats, with random gaps between them.
    // tvalid gets one assignment per edge, so a back-to-back beat keeps it high.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_alerts.push_back(supervise(beat_item));
                beat_held = 1'b0;
            end
            if (!beat_held) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 && !no_idling &&
                             $urandom_range(0, 4) == 0) begin
                    tx_gap = $urandom_range(1, 10) - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    beat_item = pending_items.pop_front();
                    beat_held = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, beat_item.warning_popup_open,
                                      beat_item.shutdown_popup_open,
                                      beat_item.ui_transition_busy,
                                      beat_item.voltage_valid,
                                      beat_item.battery_percent,
                                      beat_item.elapsed_us};
                    s_axis_tuser  <= beat_item.operation;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic string alert_label(input int f);
        case (f)
            0:       return "led_on";
            1:       return "power_off";
            2:       return "raise_shutdown";
            default: return "raise_warning";
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: check every result beat against the oldest prediction,
    // and stall in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t    want;
        logic [3:0] want_bits;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_alerts.size() == 0) begin
                $display("%0t: result beat with none expected: expected none, actual %b",
                         $time, m_axis_tdata[3:0]);
                errors++;
            end else begin
                want = expected_alerts.pop_front();
                want_bits = {want.raise_warning, want.raise_shutdown,
                             want.power_off, want.led_on};
                for (int f = 0; f < 4; f++) begin
                    if (m_axis_tdata[f] !== want_bits[f]) begin
                        $display("%0t: %s expected %b actual %b",
                                 $time, alert_label(f), want_bits[f], m_axis_tdata[f]);
                        errors++;
                    end
                end
            end
        end
        if (!no_idling && rx_stall == 0 && $urandom_range(0, 5) == 0)
            rx_stall = $urandom_range(1, 10);
        if (rx_stall > 0 && !no_idling) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall = 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: give up when no beat moves on either channel for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("battery_alert_supervisor: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it);
        pending_items.push_back(it);
    endtask

    // Wait until every queued beat has gone and every result has come back.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_items.size() != 0 || beat_held || expected_alerts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access until pready. Only call when idle.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AUTO_OFF: cfg_sel   = value[SEL_W-1:0];
            REG_WARN:     cfg_warn  = value[PCT_W-1:0];
            REG_CRITICAL: cfg_crit  = value[PCT_W-1:0];
            default:      cfg_empty = value[PCT_W-1:0];
        endcase
        // Any register write restarts the inactivity count.
        st_idle_us = '0;
    endtask

    task automatic program_regs(input logic [SEL_W-1:0] sel, input logic [PCT_W-1:0] warn,
                                input logic [PCT_W-1:0] crit, input logic [PCT_W-1:0] empty);
        wait_idle();
        apb_write(REG_AUTO_OFF, 32'(sel));
        apb_write(REG_WARN, 32'(warn));
        apb_write(REG_CRITICAL, 32'(crit));
        apb_write(REG_EMPTY, 32'(empty));
    endtask

    function automatic item_t make_tick(input logic [DT_W-1:0] dt, input logic [PCT_W-1:0] pct,
                                        input logic vv, input logic busy,
                                        input logic shut_open, input logic warn_open);
        item_t it;
        it.operation           = OP_TICK;
        it.elapsed_us          = dt;
        it.battery_percent     = pct;
        it.voltage_valid       = vv;
        it.ui_transition_busy  = busy;
        it.shutdown_popup_open = shut_open;
        it.warning_popup_open  = warn_open;
        return it;
    endfunction

    // Key press with random payload; the block must ignore everything but the kind.
    function automatic item_t make_key();
        item_t it;
        it = item_t'($urandom);
        it.operation = OP_KEY;
        return it;
    endfunction

    // Mostly valid ticks near the thresholds, with some key presses and noise.
    function automatic item_t rand_item();
        item_t it;
        int    base;
        if ($urandom_range(0, 11) == 0)
            return make_key();
        it = make_tick('0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        case ($urandom_range(0, 2))
            0:       it.elapsed_us = DT_W'($urandom_range(600000, 1048575));
            1:       it.elapsed_us = DT_W'($urandom_range(0, 150000));
            default: it.elapsed_us = DT_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       base = cfg_warn;
            1:       base = cfg_crit;
            2:       base = cfg_empty;
            3:       base = $urandom_range(1, 101);
            default: base = $urandom_range(1, 128);
        endcase
        it.battery_percent     = PCT_W'(base + $urandom_range(0, 2) - 1);
        it.voltage_valid       = ($urandom_range(0, 7) != 0);
        it.ui_transition_busy  = ($urandom_range(0, 3) == 0);
        it.shutdown_popup_open = ($urandom_range(0, 4) == 0);
        it.warning_popup_open  = ($urandom_range(0, 4) == 0);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_key_press();
        item_t it;
        it = '0;
        it.operation = OP_KEY;
        send_item(it);
        // Key press with every payload bit set
        it = '1;
        send_item(it);
        send_item(make_key());
    endtask

    // Fast blink at the critical level, then slow blink at the warning level.
    task automatic test_blinker();
        send_item(make_tick(DT_MAX, 7'd5, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_tick(DT_W'(99999), 7'd5, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_tick(DT_W'(1), 7'd5, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (5) send_item(make_tick(DT_MAX, 7'd15, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_tick('0, 7'd15, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_tick(DT_MAX, 7'd16, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Shutdown and warning checks, each blocked first by the UI conditions that hold it back.
    task automatic test_alert_checks();
        // Twenty blocked ticks guarantee the check period has passed.
        repeat (20) send_item(make_tick(DT_MAX, 7'd1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_item(make_tick(DT_MAX, 7'd1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(make_tick(DT_MAX, 7'd1, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(make_tick(DT_MAX, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        // Warning: blocked by busy and by the shutdown popup, not by its own popup.
        repeat (10) send_item(make_tick(DT_MAX, 7'd15, 1'b1, 1'b1, 1'b0, 1'b0));
        repeat (10) send_item(make_tick(DT_MAX, 7'd15, 1'b1, 1'b0, 1'b1, 1'b0));
        send_item(make_tick(DT_MAX, 7'd15, 1'b1, 1'b0, 1'b0, 1'b1));
        // The warning is given only once.
        repeat (21) send_item(make_tick(DT_MAX, 7'd2, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_voltage_unread();
        repeat (3) send_item(make_tick(DT_MAX, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_item(make_tick(DT_MAX, 7'd0, 1'b0, 1'b1, 1'b1, 1'b1));
        send_item(make_tick(DT_MAX, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Percent beyond one hundred is compared as given.
    task automatic test_percent_range();
        program_regs(SEL_OFF, 7'd100, 7'd100, 7'd100);
        send_item(make_tick(DT_MAX, PCT_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_tick(DT_MAX, 7'd100, 1'b1, 1'b0, 1'b0, 1'b0));
        program_regs(SEL_OFF, PCT_MAX, PCT_MAX, PCT_MAX);
        repeat (4) send_item(make_tick(DT_MAX, PCT_MAX, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Inactivity count: stays below the limit, cleared by a key press and by writes.
    task automatic test_auto_off_hold();
        program_regs(SEL_1_MIN, 7'd15, 7'd5, 7'd1);
        repeat (40) send_item(make_tick(DT_MAX, 7'd50, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_key());
        repeat (40) send_item(make_tick(DT_MAX, 7'd50, 1'b1, 1'b0, 1'b0, 1'b0));
        wait_idle();
        apb_write(REG_WARN, 32'd20);
        repeat (40) send_item(make_tick(DT_MAX, 7'd50, 1'b1, 1'b0, 1'b0, 1'b0));
        // Selector codes above four behave as off.
        for (int s = 5; s <= 7; s++) begin
            program_regs(SEL_W'(s), 7'd15, 7'd5, 7'd1);
            repeat (70) send_item(make_tick(DT_MAX, 7'd50, 1'b0, 1'b0, 1'b0, 1'b0));
        end
    endtask

    task automatic test_register_sweep();
        program_regs(SEL_OFF, 7'd0, 7'd0, 7'd0);
        repeat (25) send_item(rand_item());
        program_regs(SEL_30_MIN, 7'd100, 7'd100, 7'd100);
        repeat (25) send_item(rand_item());
        program_regs(SEL_15_MIN, 7'd100, 7'd50, 7'd0);
        repeat (25) send_item(rand_item());
        program_regs(SEL_5_MIN, 7'd20, 7'd10, PCT_MAX);
        repeat (25) send_item(rand_item());
    endtask

    // Random phases; the one-minute selector is kept for the final power-off.
    task automatic test_random_traffic();
        logic [SEL_W-1:0] sel;
        logic [PCT_W-1:0] pct_cfg[3];
        int               r;
        for (int phase = 0; phase < 9; phase++) begin
            r   = $urandom_range(0, 6);
            sel = (r == 0) ? SEL_OFF : SEL_W'(r + 1);
            for (int k = 0; k < 3; k++)
                pct_cfg[k] = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(0, 127))
                                                         : PCT_W'($urandom_range(0, 100));
            program_regs(sel, pct_cfg[0], pct_cfg[1], pct_cfg[2]);
            repeat (35) send_item(rand_item());
        end
    endtask

    // One minute of inactivity halts the block for good.
    task automatic test_power_off();
        program_regs(SEL_1_MIN, 7'd15, 7'd5, 7'd1);
        repeat (62) send_item(make_tick(DT_MAX, 7'd3, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(make_key());
        repeat (4) send_item(rand_item());
        // A write after the halt clears the count but not the halt.
        wait_idle();
        apb_write(REG_AUTO_OFF, 32'(SEL_OFF));
        send_item(make_key());
        repeat (4) send_item(rand_item());
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_key_press();
        test_blinker();
        test_alert_checks();
        test_voltage_unread();
        test_percent_range();
        test_auto_off_hold();
        test_register_sweep();
        test_random_traffic();
        // Drop all idling for the closing stretch.
        wait_idle();
        no_idling = 1'b1;
        test_power_off();
        wait_idle();

        if (errors == 0)
            $display("battery_alert_supervisor: match");
        else
            $display("battery_alert_supervisor: mismatch");
        $finish;
    end

endmodule
